// ===== hdl/chm_pkg.sv =====
// Package for the chained hash map engine: sizes, codes and shared types.
// No dependencies.
package chm_pkg;
  localparam int BUCKETS  = 1024;
  localparam int NODES    = 1024;
  localparam int KEY_BITS = 64;
  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(NODES);
  localparam int CW = 11;
  localparam int HW = 32;
  localparam int QDEPTH = 2;
  // slot RAM word: key, hash, next link, link valid
  localparam int SLOT_W = KEY_BITS + HW + NW + 1;
  // bucket RAM word: bucket in use, head link
  localparam int HEAD_W = NW + 1;
  localparam int STEP_W = $clog2(NODES + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0, REQ_FIND = 2'd1, REQ_REMOVE = 2'd2, REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ABSENT = 2'd1, ST_PRESENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HEAD, S_HEAD_WAIT, S_NODE_RD, S_NODE_WAIT, S_CHECK,
    S_CLEAR, S_OUT
  } state_t;

  // classified work item passed from the front to the back
  typedef struct packed {
    req_t              kind;
    logic [KEY_BITS-1:0] key;
    logic [HW-1:0]     hash;
    logic [BW-1:0]     bucket;
    logic [9:0]        handle;
    logic              handle_ok;
  } work_t;
endpackage

// ===== hdl/chm_if.sv =====
// Valid/ready channel interfaces for request and result words.
// No dependencies.
interface chm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [63:0] key_value;
  logic [31:0] key_hash;
  logic [9:0] node_handle;
  modport source(output valid, req_type, key_value, key_hash, node_handle, input ready);
  modport sink(input valid, req_type, key_value, key_hash, node_handle, output ready);
endinterface

interface chm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] result_handle;
  modport source(output valid, status, result_handle, input ready);
  modport sink(input valid, status, result_handle, output ready);
endinterface

// ===== hdl/chained_hash_map_engine.sv =====
// Top level of the chained hash map engine: front end, queue, back end.
// Depends on chm_pkg, chm_if, chm_front, chm_back.
//
//   channel  direction  word
//   in_      sink       req_type, key_value, key_hash, node_handle
//   out_     source     status, result_handle
//   cfg_     write      bucket_count
//
// Front: one word at a time through the bit-serial hash modulo unit (32 steps);
// the next word is taken once the current one is queued. Back: paced by the
// registered RAM reads, a head read and then one slot read per chain node visited;
// a clear sweeps the bucket table. Sustained rate is the slower of the two; a two-word queue decouples them.
// Reset: synchronous, active low; the back then sweeps the bucket table before
// taking work. Either side may stall; results held until taken.
module chained_hash_map_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  chm_req_if.sink     in_ch,
  chm_rsp_if.source   out_ch
);
  import chm_pkg::*;

  work_t wk_data;
  logic  wk_valid, wk_pop;

  chm_front u_front (.clk, .rst_n, .cfg_we, .cfg_wdata, .req(in_ch),
                     .wk_data, .wk_valid, .wk_pop);
  chm_back u_back (.clk, .rst_n, .wk_data, .wk_valid, .wk_pop, .rsp(out_ch));
endmodule

// ===== hdl/chm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/chm_front.sv =====
// Front end: takes request words, reduces the hash to a bucket, queues work.
// Depends on chm_pkg and chm_if.
module chm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [10:0]     cfg_wdata,
  chm_req_if.sink         req,
  output chm_pkg::work_t  wk_data,
  output logic            wk_valid,
  input  logic            wk_pop
);
  import chm_pkg::*;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] eff;
  // modulo unit: restoring subtract, one quotient bit per cycle
  logic          busy_r;
  logic [5:0]    step_r;
  logic [HW-1:0] rem_r;
  logic [HW-1:0] dvd_r;
  work_t         cur_r;
  logic [HW:0]   trial;
  logic [HW-1:0] rem_sh;
  work_t         q_r [QDEPTH];
  logic [1:0]    qcnt_r;
  logic          push;

  always_comb begin
    eff = cnt_r;
    if (cnt_r == '0) eff = CW'(1);
    if (cnt_r > CW'(BUCKETS)) eff = CW'(BUCKETS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= CW'(BUCKETS);
    else if (cfg_we) cnt_r <= cfg_wdata;
  end

  assign req.ready = !busy_r;
  assign rem_sh = {rem_r[HW-2:0], dvd_r[HW-1]};
  assign trial  = {1'b0, rem_sh} - {{(HW+1-CW){1'b0}}, eff};
  assign push   = busy_r && step_r == 6'd0 && qcnt_r != 2'(QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (!busy_r) begin
      if (req.valid) begin
        busy_r <= 1'b1;
        step_r <= 6'(HW);
      end
    end else if (step_r != 6'd0) begin
      step_r <= step_r - 6'd1;
    end else if (push) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.valid) begin
      rem_r <= '0;
      dvd_r <= req.key_hash;
      cur_r.kind      <= req_t'(req.req_type);
      cur_r.key       <= req.key_value[KEY_BITS-1:0];
      cur_r.hash      <= req.key_hash;
      cur_r.handle    <= req.node_handle;
      cur_r.handle_ok <= 32'(req.node_handle) < NODES;
      cur_r.bucket    <= '0;
    end else if (busy_r && step_r != 6'd0) begin
      dvd_r <= {dvd_r[HW-2:0], 1'b0};
      rem_r <= trial[HW] ? rem_sh : trial[HW-1:0];
      if (step_r == 6'd1)
        cur_r.bucket <= trial[HW] ? rem_sh[BW-1:0] : trial[BW-1:0];
    end
  end

  // two-entry queue, head at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) qcnt_r <= '0;
    else qcnt_r <= qcnt_r + 2'(push) - 2'(wk_pop);
  end
  always_ff @(posedge clk) begin
    if (wk_pop) q_r[0] <= (qcnt_r == 2'd2) ? q_r[1] : cur_r;
    else if (push && qcnt_r == 2'd0) q_r[0] <= cur_r;
    if (push && ((qcnt_r == 2'd1 && !wk_pop) || (qcnt_r == 2'd2)))
      q_r[1] <= cur_r;
  end
  assign wk_valid = qcnt_r != 2'd0;
  assign wk_data  = q_r[0];

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 2'(QDEPTH)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wk_pop |-> wk_valid) else $error("pop from empty queue");
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> {{(HW-BW){1'b0}}, cur_r.bucket} < HW'(eff)) else $error("bucket range");
`endif
endmodule

// ===== hdl/chm_back.sv =====
// Back end: walks and edits bucket chains held in RAMs, emits result words.
// Depends on chm_pkg, chm_if and chm_ram.
module chm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  chm_pkg::work_t wk_data,
  input  logic           wk_valid,
  output logic           wk_pop,
  chm_rsp_if.source      rsp
);
  import chm_pkg::*;

  state_t state_r, state_nxt;
  work_t  w_r;
  logic [NW-1:0] cur_r, prev_r;
  logic          has_prev_r;
  logic          found_r;
  logic [STEP_W-1:0] steps_r;
  logic [BW-1:0] clr_r;
  status_t st_r, st_nxt;
  logic [NW-1:0] res_r, res_nxt;

  // node payload held from the hit read for unlinking
  logic [NW-1:0] hn_next_r;
  logic          hn_has_r;
  // predecessor key and hash, captured when it is stepped past
  logic [KEY_BITS-1:0] pk_key_r;
  logic [HW-1:0]       pk_hash_r;

  logic              hd_we;
  logic [BW-1:0]     hd_waddr;
  logic [HEAD_W-1:0] hd_wdata, hd_rdata;
  logic              sl_we;
  logic [NW-1:0]     sl_waddr;
  logic [SLOT_W-1:0] sl_wdata, sl_rdata;

  logic                b_used;
  logic [NW-1:0]       b_head;
  logic [KEY_BITS-1:0] n_key;
  logic [HW-1:0]       n_hash;
  logic [NW-1:0]       n_next;
  logic                n_has;
  logic                hit;
  logic                more;
  logic                sweep_end;

  chm_ram #(.WIDTH(HEAD_W), .DEPTH(BUCKETS)) u_head (
    .clk, .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(w_r.bucket), .rdata(hd_rdata));
  chm_ram #(.WIDTH(SLOT_W), .DEPTH(NODES)) u_slot (
    .clk, .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(cur_r), .rdata(sl_rdata));

  assign {b_used, b_head} = hd_rdata;
  assign {n_key, n_hash, n_next, n_has} = sl_rdata;
  assign hit  = n_hash == w_r.hash && n_key == w_r.key;
  // follow the link while one exists and the walk bound is not reached
  assign more = n_has && 32'(n_next) < NODES && 32'(steps_r) < NODES - 1;
  assign sweep_end = clr_r == BW'(BUCKETS - 1);
  assign wk_pop = state_r == S_IDLE && wk_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:      if (sweep_end) state_nxt = S_IDLE;
      S_IDLE:      if (wk_valid) state_nxt = S_HEAD;
      S_HEAD:      state_nxt = (w_r.kind == REQ_CLEAR) ? S_CLEAR : S_HEAD_WAIT;
      S_HEAD_WAIT: state_nxt = b_used ? S_NODE_RD : S_CHECK;
      S_NODE_RD:   state_nxt = S_NODE_WAIT;
      S_NODE_WAIT: state_nxt = (!hit && more) ? S_NODE_RD : S_CHECK;
      S_CHECK:     state_nxt = S_OUT;
      S_CLEAR:     if (sweep_end) state_nxt = S_OUT;
      S_OUT:       if (rsp.ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

  // sweep address for the bucket table, after reset and on clear
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == S_INIT || state_r == S_CLEAR) begin
      if (sweep_end) clr_r <= '0;
      else clr_r <= clr_r + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wk_pop) w_r <= wk_data;
    unique case (state_r)
      S_HEAD: begin
        found_r <= 1'b0; has_prev_r <= 1'b0; steps_r <= '0;
      end
      S_HEAD_WAIT: cur_r <= b_head;
      S_NODE_WAIT: begin
        if (hit) begin
          found_r <= 1'b1; hn_next_r <= n_next; hn_has_r <= n_has;
        end else if (more) begin
          prev_r <= cur_r; has_prev_r <= 1'b1; cur_r <= n_next;
          pk_key_r <= n_key; pk_hash_r <= n_hash;
          steps_r <= steps_r + STEP_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt  = ST_OK;
    res_nxt = '0;
    unique case (w_r.kind)
      REQ_INSERT: if (found_r) begin
                    st_nxt = ST_PRESENT; res_nxt = cur_r;
                  end else if (!w_r.handle_ok) st_nxt = ST_ABSENT;
      REQ_FIND, REQ_REMOVE: if (found_r) res_nxt = cur_r; else st_nxt = ST_ABSENT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK || state_r == S_CLEAR) begin
      st_r  <= st_nxt;
      res_r <= res_nxt;
    end
  end

  // memory writes: table sweep, or the edit in the decision cycle
  always_comb begin
    hd_we = 1'b0; hd_waddr = w_r.bucket; hd_wdata = '0;
    sl_we = 1'b0; sl_waddr = w_r.handle[NW-1:0]; sl_wdata = '0;
    if (state_r == S_INIT || state_r == S_CLEAR) begin
      hd_we = 1'b1; hd_waddr = clr_r;
    end else if (state_r == S_CHECK) begin
      if (w_r.kind == REQ_INSERT && !found_r && w_r.handle_ok) begin
        hd_we = 1'b1; hd_wdata = {1'b1, w_r.handle[NW-1:0]};
        sl_we = 1'b1;
        sl_wdata = {w_r.key, w_r.hash, b_used ? b_head : {NW{1'b0}}, b_used};
      end else if (w_r.kind == REQ_REMOVE && found_r) begin
        if (has_prev_r) begin
          sl_we = 1'b1; sl_waddr = prev_r;
          sl_wdata = {pk_key_r, pk_hash_r, hn_next_r, hn_has_r};
        end else begin
          // drop the head; empty the bucket when nothing follows
          hd_we = 1'b1;
          hd_wdata = hn_has_r ? {1'b1, hn_next_r} : {HEAD_W{1'b0}};
        end
      end
    end
  end

  assign rsp.valid = state_r == S_OUT;
  assign rsp.status = st_r;
  assign rsp.result_handle = res_r;

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) &&
    $stable(rsp.result_handle)) else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wk_pop |=> state_r == S_HEAD) else $error("pop outside idle");
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid && rsp.status == ST_ABSENT |-> rsp.result_handle == '0)
    else $error("absent with handle");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NODE_WAIT |-> 32'(steps_r) < NODES) else $error("walk too long");
`endif
endmodule

// ===== tb/tb_chained_hash_map_engine.sv =====
// Self-checking testbench for the chained hash map engine: random and directed
// insert/find/remove/clear words checked against a shadow hash map.
// Depends on chm_pkg, chm_if and the chained_hash_map_engine RTL.
`timescale 1ns / 100ps

module tb_chained_hash_map_engine;
  import chm_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [9:0] handle;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  chm_req_if in_ch();
  chm_rsp_if out_ch();

  chained_hash_map_engine u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // shadow hash map
  logic [10:0]         bucket_cnt_reg;
  logic [9:0]          head_of[BUCKETS];
  logic                used_of[BUCKETS];
  logic [9:0]          next_of[NODES];
  logic                has_next_of[NODES];
  logic [KEY_BITS-1:0] key_of[NODES];
  logic [31:0]         hash_of[NODES];

  map_result_t expected_q[$];
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      cycle_cnt = 0;

  // keys live in a small pool so hits and chains are common
  logic [63:0] key_pool[64];
  logic [31:0] hash_pool[64];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.key_value = '0;
    in_ch.key_hash = '0;
    in_ch.node_handle = '0;
    out_ch.ready = 1'b0;
  end

  task automatic shadow_reset();
    bucket_cnt_reg = 11'd1024;
    for (int i = 0; i < BUCKETS; i++) begin
      used_of[i] = 1'b0;
      head_of[i] = '0;
    end
    for (int i = 0; i < NODES; i++) begin
      next_of[i] = '0;
      has_next_of[i] = 1'b0;
      key_of[i] = '0;
      hash_of[i] = '0;
    end
  endtask

  function automatic int bucket_of(logic [31:0] h);
    int c;
    c = bucket_cnt_reg;
    if (c == 0) c = 1;
    if (c > BUCKETS) c = BUCKETS;
    return int'(h % c);
  endfunction

  // walk a chain; returns hit, the node and its predecessor
  function automatic bit chain_search(int b, logic [63:0] k, logic [31:0] h,
                                      output int hit, output int prev,
                                      output bit has_prev);
    int cur;
    hit = 0; prev = 0; has_prev = 0;
    if (!used_of[b]) return 0;
    cur = head_of[b];
    for (int s = 0; s < NODES; s++) begin
      if (cur >= NODES) return 0;
      if (hash_of[cur] == h && key_of[cur] == k) begin
        hit = cur;
        return 1;
      end
      if (!has_next_of[cur]) return 0;
      prev = cur;
      has_prev = 1;
      cur = next_of[cur];
    end
    return 0;
  endfunction

  function automatic map_result_t map_predict(req_t kind, logic [63:0] k,
                                              logic [31:0] h, logic [9:0] hd);
    map_result_t r;
    int b, hit, prev;
    bit hp, found;
    b = bucket_of(h);
    r.status = ST_OK;
    r.handle = '0;
    case (kind)
      REQ_INSERT: begin
        found = chain_search(b, k, h, hit, prev, hp);
        if (found) begin
          r.status = ST_PRESENT;
          r.handle = hit[9:0];
        end else if (int'(hd) >= NODES) begin
          r.status = ST_ABSENT;
        end else begin
          key_of[hd] = k;
          hash_of[hd] = h;
          has_next_of[hd] = used_of[b];
          next_of[hd] = used_of[b] ? head_of[b] : '0;
          head_of[b] = hd;
          used_of[b] = 1'b1;
        end
      end
      REQ_FIND: begin
        found = chain_search(b, k, h, hit, prev, hp);
        if (found) r.handle = hit[9:0];
        else r.status = ST_ABSENT;
      end
      REQ_REMOVE: begin
        found = chain_search(b, k, h, hit, prev, hp);
        if (found) begin
          if (hp) begin
            has_next_of[prev] = has_next_of[hit];
            next_of[prev] = next_of[hit];
          end else if (has_next_of[hit]) begin
            head_of[b] = next_of[hit];
          end else begin
            used_of[b] = 1'b0;
            head_of[b] = '0;
          end
          r.handle = hit[9:0];
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        for (int i = 0; i < BUCKETS; i++) used_of[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, n_checked);
  endtask

  // send one request word, idling at random first; valid stays up after the
  // accepting edge so that words can follow back to back
  task automatic send_word(req_t kind, logic [63:0] k, logic [31:0] h, logic [9:0] hd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.key_value <= k;
    in_ch.key_hash <= h;
    in_ch.node_handle <= hd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(map_predict(kind, k, h, hd));
    n_sent++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", int'(out_ch.status), -1);
        end else begin
          map_result_t e;
          e = expected_q.pop_front();
          if (out_ch.status !== e.status)
            report_mismatch("status", int'(out_ch.status), int'(e.status));
          if (out_ch.result_handle !== e.handle)
            report_mismatch("handle", int'(out_ch.result_handle), int'(e.handle));
        end
        n_checked++;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 20000000) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [10:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bucket_cnt_reg = v;
  endtask

  task automatic test_directed();
    send_word(REQ_FIND, 64'h0, 32'h0, 10'd0);
    send_word(REQ_REMOVE, 64'h0, 32'h0, 10'd0);
    send_word(REQ_INSERT, 64'h0, 32'h0, 10'd0);
    send_word(REQ_INSERT, 64'h0, 32'h0, 10'd5);
    send_word(REQ_INSERT, '1, '1, 10'd1023);
    send_word(REQ_FIND, '1, '1, 10'd0);
    // same hash, different key: collision in one chain
    send_word(REQ_INSERT, 64'h1, 32'h0, 10'd1);
    send_word(REQ_INSERT, 64'h2, 32'h400, 10'd2);
    send_word(REQ_FIND, 64'h0, 32'h0, 10'd0);
    send_word(REQ_REMOVE, 64'h1, 32'h0, 10'd0);
    send_word(REQ_FIND, 64'h2, 32'h400, 10'd0);
    send_word(REQ_REMOVE, 64'h2, 32'h400, 10'd0);
    send_word(REQ_REMOVE, 64'h0, 32'h0, 10'd0);
    send_word(REQ_FIND, 64'h0, 32'h0, 10'd0);
    // reinsert of a linked handle overwrites the slot
    send_word(REQ_INSERT, 64'hA5, 32'h7, 10'd1023);
    send_word(REQ_FIND, 64'hA5, 32'h7, 10'd0);
    send_word(REQ_CLEAR, '1, '1, '1);
    send_word(REQ_FIND, '1, '1, 10'd0);
    send_word(REQ_INSERT, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 10'h2AA);
    send_word(REQ_INSERT, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 10'h155);
    send_word(REQ_REMOVE, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 10'd0);
    send_word(REQ_CLEAR, 64'h0, 32'h0, 10'd0);
  endtask

  task automatic test_random(int n);
    int      i;
    int      kind_sel;
    req_t    kind;
    logic [63:0] k;
    logic [31:0] h;
    for (i = 0; i < n; i++) begin
      kind_sel = $urandom_range(99);
      if (kind_sel < 40) kind = REQ_INSERT;
      else if (kind_sel < 70) kind = REQ_FIND;
      else if (kind_sel < 98) kind = REQ_REMOVE;
      else kind = REQ_CLEAR;
      if ($urandom_range(9) < 8) begin
        int p;
        p = $urandom_range(63);
        k = key_pool[p];
        h = hash_pool[p];
      end else begin
        k = {$urandom, $urandom};
        h = $urandom;
      end
      send_word(kind, k, h, 10'($urandom));
    end
  endtask

  task automatic test_bucket_counts();
    // extremes of the register, zero and above range included
    write_bucket_count(11'd1);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(250);
    write_bucket_count(11'd0);
    send_idle_pct = 56; recv_stall_pct = 0;
    test_random(150);
    write_bucket_count(11'd2047);
    send_idle_pct = 0; recv_stall_pct = 56;
    test_random(250);
    write_bucket_count(11'd7);
    send_idle_pct = 31; recv_stall_pct = 31;
    test_random(350);
    write_bucket_count(11'd1024);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(350);
    write_bucket_count(11'($urandom_range(2, 1023)));
    send_idle_pct = 31; recv_stall_pct = 31;
    test_random(480);
  endtask

  initial begin
    shadow_reset();
    for (int i = 0; i < 64; i++) begin
      key_pool[i] = {$urandom, $urandom};
      hash_pool[i] = (i < 32) ? 32'(i % 8) : $urandom;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_bucket_counts();
    drain();
    $display("sent %0d request words, checked %0d result words", n_sent, n_checked);
    $display("bucket counts 0, 1, 7, 1024, 2047 and random, with sender and receiver stalls");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/chm_pkg.sv
hdl/chm_if.sv
hdl/chm_ram.sv
hdl/chm_front.sv
hdl/chm_back.sv
hdl/chained_hash_map_engine.sv
tb/tb_chained_hash_map_engine.sv
